### rtl/core/rlht_pkg.sv
// ----------------------------------------------------------------------------
// rlht_pkg
// Shared types, register codes and the CORDIC arctangent table of the
// rate-limited heading tracker.
// ----------------------------------------------------------------------------
package rlht_pkg;

    // angle and field widths
    localparam int HEADING_W = 16;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = 32;

    // vector registers: coordinates scaled to 2^40, plus CORDIC growth and sign
    localparam int XY_W        = 44;
    localparam int SCALE_EXP   = 40;
    localparam int TABLE_LEN   = 24;
    localparam int STEP_W      = 5;
    localparam int HALF_TURN   = 32768;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIVOT_X  = 2'd0,
        REG_PIVOT_Y  = 2'd1,
        REG_MAX_STEP = 2'd2
    } t_reg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_BEARING,
        ST_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rotate;
        logic bearing;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_step;
    } t_sts;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/rlht_if.sv
// ----------------------------------------------------------------------------
// rlht interfaces
// Valid/ready channels of the heading tracker: target input, heading output
// and configuration writes.
// ----------------------------------------------------------------------------

// target input channel
interface rlht_in_if #(
    parameter int COORD_BITS = 11
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         target_x;
    logic [COORD_BITS-1:0]         target_y;
    logic [rlht_pkg::TICKS_W-1:0]  elapsed_ticks;

    modport source (output valid, target_x, target_y, elapsed_ticks, input ready);
    modport sink   (input valid, target_x, target_y, elapsed_ticks, output ready);
endinterface

// heading output channel
interface rlht_out_if;
    logic                           valid;
    logic                           ready;
    logic [rlht_pkg::HEADING_W-1:0] heading;

    modport source (output valid, heading, input ready);
    modport sink   (input valid, heading, output ready);
endinterface

// configuration write channel
interface rlht_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rlht_pkg::CFG_IDX_W-1:0] index;
    logic [rlht_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rlht_ctrl.sv
// ----------------------------------------------------------------------------
// rlht_ctrl
// Sequencer of the heading tracker: load, CORDIC rotations, bearing and
// difference, then clamp and commit into the output register.
// ----------------------------------------------------------------------------
module rlht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rlht_pkg::t_sts i_sts,
    output rlht_pkg::t_cmd o_cmd
);
    import rlht_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // output register can take a result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (i_sts.last_step) n_state = ST_BEARING;
            end
            ST_BEARING: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ROTATE: begin
                o_cmd.rotate = 1'b1;
            end
            ST_BEARING: begin
                o_cmd.bearing = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/rlht_dp.sv
// ----------------------------------------------------------------------------
// rlht_dp
// Datapath of the heading tracker: configuration registers, vectoring CORDIC,
// step-limit multiplier, shortest difference, clamp and heading register.
// ----------------------------------------------------------------------------
module rlht_dp #(
    parameter int COORD_BITS = 11,
    parameter int NUM_STEPS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rlht_pkg::t_cmd                    i_cmd,
    output rlht_pkg::t_sts                    o_sts,
    input  logic [COORD_BITS-1:0]             i_target_x,
    input  logic [COORD_BITS-1:0]             i_target_y,
    input  logic [rlht_pkg::TICKS_W-1:0]      i_ticks,
    input  logic                              i_cfg_we,
    input  logic [rlht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlht_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic [rlht_pkg::HEADING_W-1:0]    o_heading
);
    import rlht_pkg::*;

    localparam int SHIFT  = SCALE_EXP - COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;

    // configuration
    logic [COORD_BITS-1:0] r_pivot_x;
    logic [COORD_BITS-1:0] r_pivot_y;
    logic [TICKS_W-1:0]    r_max_step;

    // CORDIC state
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic [ACC_W-1:0]       r_acc;
    logic [STEP_W-1:0]      r_step;
    logic                   r_zero;
    logic [PROD_W-1:0]      r_prod;

    // difference stage
    logic signed [HEADING_W-1:0] r_diff;
    logic [HEADING_W-1:0]        r_limit;

    // heading state and result
    logic [HEADING_W-1:0] r_heading;
    logic [HEADING_W-1:0] r_out;

    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [XY_W-1:0]   w_x0;
    logic signed [XY_W-1:0]   w_y0;
    logic signed [XY_W-1:0]   w_xs;
    logic signed [XY_W-1:0]   w_ys;
    logic [ACC_W-1:0]         w_angle;
    logic [ACC_W-1:0]         w_acc_rnd;
    logic [HEADING_W-1:0]     w_bearing;
    logic [HEADING_W-1:0]     w_raw;
    logic signed [HEADING_W:0] w_diff_ext;
    logic signed [HEADING_W:0] w_lim_pos;
    logic signed [HEADING_W:0] w_lim_neg;
    logic signed [HEADING_W:0] w_clamp;
    logic [HEADING_W-1:0]     w_new_heading;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_x  <= COORD_BITS'(400);
            r_pivot_y  <= COORD_BITS'(300);
            r_max_step <= TICKS_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PIVOT_X:  r_pivot_x  <= i_cfg_data[COORD_BITS-1:0];
                REG_PIVOT_Y:  r_pivot_y  <= i_cfg_data[COORD_BITS-1:0];
                REG_MAX_STEP: r_max_step <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // vector from pivot to target, scaled to the CORDIC format
    assign w_dx = $signed({1'b0, i_target_x}) - $signed({1'b0, r_pivot_x});
    assign w_dy = $signed({1'b0, i_target_y}) - $signed({1'b0, r_pivot_y});
    assign w_x0 = XY_W'(w_dx) <<< SHIFT;
    assign w_y0 = XY_W'(w_dy) <<< SHIFT;

    // one rotation per cycle
    assign w_xs    = r_x >>> r_step;
    assign w_ys    = r_y >>> r_step;
    assign w_angle = atan_entry(r_step);

    assign o_sts.last_step = (r_step == STEP_W'(NUM_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // left half-plane is turned by half a turn first
            if (w_dx < 0) begin
                r_x   <= -w_x0;
                r_y   <= -w_y0;
                r_acc <= 32'h80000000;
            end else begin
                r_x   <= w_x0;
                r_y   <= w_y0;
                r_acc <= '0;
            end
            r_zero <= (w_dx == 0) && (w_dy == 0);
            r_prod <= PROD_W'(r_max_step) * PROD_W'(i_ticks);
        end else if (i_cmd.rotate) begin
            if (r_y >= 0) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_acc <= r_acc + w_angle;
            end else begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_acc <= r_acc - w_angle;
            end
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_step <= '0;
        else if (i_cmd.load)
            r_step <= '0;
        else if (i_cmd.rotate && !o_sts.last_step)
            r_step <= r_step + 1'b1;
    end

    // bearing rounded to 16 bits, shortest difference and saturated limit
    assign w_acc_rnd = r_acc + 32'h00008000;
    assign w_bearing = r_zero ? '0 : w_acc_rnd[ACC_W-1:ACC_W-HEADING_W];
    assign w_raw     = w_bearing - r_heading;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bearing) begin
            r_diff  <= $signed(w_raw);
            r_limit <= (r_prod > PROD_W'(HALF_TURN)) ? HEADING_W'(HALF_TURN)
                                                     : r_prod[HEADING_W-1:0];
        end
    end

    // clamp to the limit and step the heading
    assign w_diff_ext = {r_diff[HEADING_W-1], r_diff};
    assign w_lim_pos  = $signed({1'b0, r_limit});
    assign w_lim_neg  = -w_lim_pos;

    always_comb begin
        if (w_diff_ext > w_lim_pos)
            w_clamp = w_lim_pos;
        else if (w_diff_ext < w_lim_neg)
            w_clamp = w_lim_neg;
        else
            w_clamp = w_diff_ext;
    end

    assign w_new_heading = r_heading + w_clamp[HEADING_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_heading <= '0;
        else if (i_cmd.commit)
            r_heading <= w_new_heading;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit)
            r_out <= w_new_heading;
    end

    assign o_heading = r_out;

endmodule

### rtl/core/rate_limited_heading_tracker.sv
// Sequence: after an input transfer, one CORDIC rotation per cycle, then
// difference, then clamp and commit into the output register.
// One input at a time, set by the single shared rotation stage; a held result
// stalls the commit and with it the next input.
// Reset: synchronous, active low; heading 0, pivot (400, 300), step limit 8.
// ----------------------------------------------------------------------------
// rate_limited_heading_tracker
// Turns a heading towards the bearing of a target point from a pivot, limited
// to a configured step per elapsed tick.
// ----------------------------------------------------------------------------
module rate_limited_heading_tracker #(
    parameter int COORD_BITS   = 11,
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rlht_in_if.sink   i_in,
    rlht_out_if.source o_out,
    rlht_cfg_if.sink  i_cfg
);
    import rlht_pkg::*;

    localparam int NUM_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;

    rlht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rlht_dp #(
        .COORD_BITS (COORD_BITS),
        .NUM_STEPS  (NUM_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_target_x  (i_in.target_x),
        .i_target_y  (i_in.target_y),
        .i_ticks     (i_in.elapsed_ticks),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_heading   (o_out.heading)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rate-limited heading tracker: a directed table
// (half-turn ties, zero limit, zero vector, extreme points) followed by
// random targets over several pivot and step settings, with bursty input
// traffic and a patterned output stall. Every heading is checked in order
// against the table or a bit-accurate CORDIC and slew-limit predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import rlht_pkg::*;

    localparam int COORD_BITS      = 11;
    localparam int CORDIC_STEPS    = 16;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int PHASES          = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 40;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // arctangent steps, 2^32 units per turn
    localparam logic [0:23][31:0] ARC_TAB = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // directed stimulus row; heading is used only where typed is set
    typedef struct packed {
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [TICKS_W-1:0]    ticks;
        logic                  typed;
        logic [HEADING_W-1:0]  heading;
    } t_plan_row;

    localparam int PLAN_LEN = 21;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // zero vector, then zero limit
        '{11'd400,  11'd300,  16'd1,     1'b1, 16'd0},
        '{11'd2047, 11'd300,  16'd0,     1'b1, 16'd0},
        // clamped ladder up to half a turn
        '{11'd400,  11'd2047, 16'd1024,  1'b1, 16'd8192},
        '{11'd0,    11'd300,  16'd1024,  1'b1, 16'd16384},
        '{11'd0,    11'd300,  16'd1024,  1'b1, 16'd24576},
        '{11'd400,  11'd0,    16'd1024,  1'b1, 16'd32768},
        // half-turn difference with a small limit moves by minus the limit
        '{11'd400,  11'd300,  16'd1,     1'b1, 16'd32760},
        '{11'd400,  11'd0,    16'd1,     1'b1, 16'd32768},
        // half-turn difference with the limit saturated
        '{11'd400,  11'd300,  16'd65535, 1'b1, 16'd0},
        '{11'd400,  11'd2047, 16'd1024,  1'b1, 16'd8192},
        '{11'd0,    11'd300,  16'd1024,  1'b1, 16'd16384},
        '{11'd0,    11'd300,  16'd1024,  1'b1, 16'd24576},
        '{11'd400,  11'd0,    16'd1024,  1'b1, 16'd32768},
        // limit exactly half a turn
        '{11'd400,  11'd300,  16'd4096,  1'b1, 16'd0},
        // corners and odd points, predicted
        '{11'd0,    11'd0,    16'd65535, 1'b0, 16'd0},
        '{11'd2047, 11'd2047, 16'd300,   1'b0, 16'd0},
        '{11'd0,    11'd2047, 16'd65535, 1'b0, 16'd0},
        '{11'd2047, 11'd0,    16'd7,     1'b0, 16'd0},
        '{11'd2047, 11'd2047, 16'd0,     1'b0, 16'd0},
        '{11'd1023, 11'd1024, 16'd65535, 1'b0, 16'd0},
        '{11'd401,  11'd300,  16'd2,     1'b0, 16'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rlht_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
    rlht_out_if out_if ();
    rlht_cfg_if cfg_if ();

    rate_limited_heading_tracker #(
        .COORD_BITS  (COORD_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // predictor state: mirrored registers and heading
    logic [COORD_BITS-1:0] pivot_col;
    logic [COORD_BITS-1:0] pivot_row;
    logic [15:0]           step_cap;
    logic [HEADING_W-1:0]  heading_now;

    logic [HEADING_W-1:0] heading_due [$];
    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_left  = 0;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // vectoring CORDIC bearing of (dx, dy)
    function automatic logic [HEADING_W-1:0] bearing_cordic(input int dx, input int dy);
        longint      vx;
        longint      vy;
        longint      nx;
        longint      ny;
        logic [31:0] angle;
        int          n_steps;
        if (dx == 0 && dy == 0)
            return '0;
        vx    = longint'(dx) * (longint'(1) << (SCALE_EXP - COORD_BITS));
        vy    = longint'(dy) * (longint'(1) << (SCALE_EXP - COORD_BITS));
        angle = '0;
        // left half plane: turn by half a turn first
        if (vx < 0) begin
            vx    = -vx;
            vy    = -vy;
            angle = 32'h8000_0000;
        end
        n_steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int n = 0; n < n_steps; n++) begin
            if (vy >= 0) begin
                nx    = vx + (vy >>> n);
                ny    = vy - (vx >>> n);
                angle = angle + ARC_TAB[n];
            end else begin
                nx    = vx - (vy >>> n);
                ny    = vy + (vx >>> n);
                angle = angle - ARC_TAB[n];
            end
            vx = nx;
            vy = ny;
        end
        angle = angle + 32'h0000_8000;
        return angle[31:16];
    endfunction

    // heading after one update, slew limited
    function automatic logic [HEADING_W-1:0] next_heading(input logic [COORD_BITS-1:0] tx,
                                                        input logic [COORD_BITS-1:0] ty,
                                                        input logic [TICKS_W-1:0] ticks);
        int                   dx;
        int                   dy;
        int                   turn;
        longint               lim;
        logic [HEADING_W-1:0] gap16;
        dx    = int'(tx) - int'(pivot_col);
        dy    = int'(ty) - int'(pivot_row);
        lim   = longint'(step_cap) * longint'(ticks);
        gap16 = bearing_cordic(dx, dy) - heading_now;
        turn  = (gap16 >= 16'd32768) ? int'(gap16) - 65536 : int'(gap16);
        if (lim > HALF_TURN)
            lim = HALF_TURN;
        if (turn > lim)
            turn = int'(lim);
        else if (turn < -lim)
            turn = -int'(lim);
        return heading_now + 16'(turn);
    endfunction

    function automatic logic [COORD_BITS-1:0] clip_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    // random target, weighted towards axes, diagonals and the pivot
    task automatic pick_target(output logic [COORD_BITS-1:0] tx,
                               output logic [COORD_BITS-1:0] ty);
        int d;
        int sx;
        int sy;
        d  = $urandom_range(1, 700);
        sx = $urandom_range(0, 1) ? d : -d;
        sy = $urandom_range(0, 1) ? d : -d;
        case ($urandom_range(0, 9))
            0: begin
                tx = pivot_col;
                ty = pivot_row;
            end
            1, 2: begin
                tx = clip_coord(int'(pivot_col) + int'($urandom_range(0, 6)) - 3);
                ty = clip_coord(int'(pivot_row) + int'($urandom_range(0, 6)) - 3);
            end
            3: begin
                tx = pivot_col;
                ty = COORD_BITS'($urandom);
            end
            4: begin
                tx = COORD_BITS'($urandom);
                ty = pivot_row;
            end
            5: begin
                tx = clip_coord(int'(pivot_col) + sx);
                ty = clip_coord(int'(pivot_row) + sy);
            end
            default: begin
                tx = COORD_BITS'($urandom);
                ty = COORD_BITS'($urandom);
            end
        endcase
    endtask

    function automatic logic [TICKS_W-1:0] pick_ticks();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return TICKS_W'($urandom_range(1, 64));
            5:       return TICKS_W'($urandom_range(65, 4200));
            default: return TICKS_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [HEADING_W-1:0] want,
                                   input logic [HEADING_W-1:0] got);
        if (mismatch_count < PRINT_LIMIT)
            $display("cycle %0d: %s: expected heading %0d, got %0d",
                     cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // one target transfer, in bursts with random gaps
    task automatic send_target(input logic [COORD_BITS-1:0] tx,
                               input logic [COORD_BITS-1:0] ty,
                               input logic [TICKS_W-1:0] ticks,
                               input logic typed,
                               input logic [HEADING_W-1:0] typed_heading);
        int                   gap;
        logic [HEADING_W-1:0] due;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_if.valid         <= 1'b1;
        in_if.target_x      <= tx;
        in_if.target_y      <= ty;
        in_if.elapsed_ticks <= ticks;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        burst_left--;
        due         = typed ? typed_heading : next_heading(tx, ty, ticks);
        heading_now = due;
        heading_due.push_back(due);
    endtask

    // hold the input off until every heading has come out
    task automatic drain_results();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (heading_due.size() != 0)
            @(posedge i_clk);
    endtask

    // one register transfer; valid stays high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
    endtask

    task automatic program_settings(input logic [15:0] px, input logic [15:0] py,
                                    input logic [15:0] st);
        cfg_write(REG_PIVOT_X, px);
        pivot_col = px[COORD_BITS-1:0];
        cfg_write(REG_UNUSED, 16'($urandom));
        cfg_write(REG_PIVOT_Y, py);
        pivot_row = py[COORD_BITS-1:0];
        cfg_write(REG_MAX_STEP, st);
        step_cap = st;
        cfg_if.valid <= 1'b0;
    endtask

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rate_limited_heading_tracker verification failed");
            $finish;
        end
    end

    // output stall pattern, reloaded with a new pattern after a random run
    always @(posedge i_clk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom) | 16'h0001;
                2:       ready_pattern <= 16'h8001;
                default: ready_pattern <= 16'hAAAA;
            endcase
            pattern_left <= $urandom_range(50, 300);
        end else begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            pattern_left  <= pattern_left - 1;
        end
        out_if.ready <= ready_pattern[15];
    end

    // compare each heading transfer with the oldest expectation
    always @(posedge i_clk) begin : check_heading
        logic [HEADING_W-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (heading_due.size() == 0) begin
                report_mismatch("heading with nothing expected", '0, out_if.heading);
            end else begin
                want = heading_due.pop_front();
                if (out_if.heading !== want)
                    report_mismatch("heading mismatch", want, out_if.heading);
            end
        end
    end

    initial begin : stimulus
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [15:0]           px;
        logic [15:0]           py;
        logic [15:0]           st;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.target_x      <= '0;
        in_if.target_y      <= '0;
        in_if.elapsed_ticks <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= REG_PIVOT_X;
        cfg_if.data         <= '0;
        pivot_col   = 11'd400;
        pivot_row   = 11'd300;
        step_cap    = 16'd8;
        heading_now = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table on the reset settings
        for (int r = 0; r < PLAN_LEN; r++)
            send_target(PLAN[r].tx, PLAN[r].ty, PLAN[r].ticks, PLAN[r].typed, PLAN[r].heading);

        // random phases, each on its own register settings
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    px = 16'h0000;
                    py = 16'h0000;
                    st = 16'hFFFF;
                end
                1: begin
                    px = 16'hFFFF;
                    py = 16'hF7FF;
                    st = 16'h0001;
                end
                2: begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    st = 16'h0000;
                end
                3: begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    st = 16'($urandom_range(1, 300));
                end
                4: begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    st = 16'($urandom);
                end
                default: begin
                    px = 16'd400;
                    py = 16'd300;
                    st = 16'd8;
                end
            endcase
            program_settings(px, py, st);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick_target(tx, ty);
                send_target(tx, ty, pick_ticks(), 1'b0, '0);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (CORDIC_STEPS + 10) @(posedge i_clk);
        if (mismatch_count == 0 && heading_due.size() == 0)
            $display("rate_limited_heading_tracker verification clean");
        else
            $display("rate_limited_heading_tracker verification failed");
        $finish;
    end

endmodule
